/* design/ufpc_pkg.sv */
// Shared types and constants of the union-find engine.
`timescale 1ns / 1ps
package ufpc_pkg;

  localparam int unsigned CellW      = 10;
  localparam int unsigned TableDepth = 1024;

  typedef enum logic [1:0] {
    OP_FIND  = 2'd0,
    OP_MERGE = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [CellW-1:0] cell_a;
    logic [CellW-1:0] cell_b;
  } req_t;

  typedef struct packed {
    logic [CellW-1:0] root;
    logic             joined;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_COMP,
    S_FDONE,
    S_STARTB,
    S_LINK,
    S_CLEAR,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_A,
    RES_ROOT,
    RES_LINK
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     walk_start;
    logic     sel_b;
    logic     walk_next;
    logic     root_take;
    logic     comp_step;
    logic     save_ra;
    logic     link;
    logic     res_load;
    res_sel_e res_sel;
    logic     sweep;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic a_active;
    logic b_active;
    logic par_is_cur;
    logic start_is_cur;
    logic par_is_root;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

endpackage

/* design/union_find_path_compression.sv */
// A find walks the chain from cell_a to its root and compresses it; a merge walks both
// chains and links them, or only a's chain with cell_b off the grid; a clear sweeps the table;
// a spare opcode or an off-grid cell_a is answered without a walk. One request at a time: the
// next is taken only after the result of the last is loaded into the output register.
// A new request is taken while the previous result still waits on the output.
// After reset the active cells of the table are swept to the identity with input stalled.
`timescale 1ns / 1ps
module union_find_path_compression #(
  parameter int unsigned GRID_SIDE = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ufpc_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ufpc_pkg::rsp_t out_rsp_o
);
  import ufpc_pkg::*;

  localparam int unsigned GridCells   = GRID_SIDE * GRID_SIDE;
  localparam int unsigned ActiveCells = (GridCells < TableDepth) ? GridCells : TableDepth;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ufpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ufpc_dp #(
    .ActiveCells (ActiveCells)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

  // only one writer of the parent table per cycle
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.sweep, cmd.comp_step, cmd.link}))
    else $error("parent table written by more than one source");

  a_sweep_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sweep |-> in_stall_o)
    else $error("request accepted during table sweep");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("pending result overwritten");

  a_join_on_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.res_load && cmd.res_sel == RES_LINK) |-> sts.op == OP_MERGE)
    else $error("link result outside a merge");

endmodule

/* design/ufpc_dp.sv */
// Datapath: parent table memory, walk registers, result and output registers.
`timescale 1ns / 1ps
module ufpc_dp #(
  parameter int unsigned ActiveCells = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ufpc_pkg::req_t   in_req_i,
  input  ufpc_pkg::dp_cmd_t cmd_i,
  output ufpc_pkg::dp_sts_t sts_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output ufpc_pkg::rsp_t   out_rsp_o
);
  import ufpc_pkg::*;

  localparam int unsigned  LimW     = CellW + 1;
  localparam logic [LimW-1:0]  ActiveLim = LimW'(ActiveCells);
  localparam logic [CellW-1:0] LastCell  = CellW'(ActiveCells - 1);

  logic [CellW-1:0] mem [TableDepth];

  logic [1:0]       op_q;
  logic [CellW-1:0] a_q, b_q, cur_q, start_q, root_q, n_q, ra_q, rdata_q;
  logic [CellW-1:0] res_root_q;
  logic             res_joined_q;
  rsp_t             out_q;
  logic             out_valid_q, out_valid_d;
  logic [CellW-1:0] cnt_q, cnt_d;

  logic [CellW-1:0] raddr, waddr, wdata;
  logic             we;
  logic             ra_ne_root;

  assign ra_ne_root = (ra_q != root_q);

  always_comb begin
    raddr = rdata_q;
    priority if (cmd_i.walk_start) begin
      raddr = cmd_i.sel_b ? b_q : a_q;
    end else if (cmd_i.root_take) begin
      raddr = start_q;
    end else begin
      raddr = rdata_q;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = n_q;
    wdata = root_q;
    priority if (cmd_i.sweep) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = cnt_q;
    end else if (cmd_i.comp_step) begin
      we    = 1'b1;
      waddr = n_q;
      wdata = root_q;
    end else if (cmd_i.link && ra_ne_root) begin
      we    = 1'b1;
      waddr = ra_q;
      wdata = root_q;
    end else begin
      we = 1'b0;
    end
  end

  // Read returns the old word on a same-address write; the sequencer never relies on it.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_req_i.opcode;
      a_q  <= in_req_i.cell_a;
      b_q  <= in_req_i.cell_b;
    end
    if (cmd_i.walk_start) begin
      cur_q   <= cmd_i.sel_b ? b_q : a_q;
      start_q <= cmd_i.sel_b ? b_q : a_q;
    end else if (cmd_i.walk_next) begin
      cur_q <= rdata_q;
    end
    if (cmd_i.root_take) begin
      root_q <= cur_q;
      n_q    <= start_q;
    end else if (cmd_i.comp_step) begin
      n_q <= rdata_q;
    end
    if (cmd_i.save_ra) begin
      ra_q <= root_q;
    end
    if (cmd_i.res_load) begin
      unique case (cmd_i.res_sel)
        RES_ZERO: begin
          res_root_q   <= '0;
          res_joined_q <= 1'b0;
        end
        RES_A: begin
          res_root_q   <= a_q;
          res_joined_q <= 1'b0;
        end
        RES_ROOT: begin
          res_root_q   <= root_q;
          res_joined_q <= 1'b0;
        end
        RES_LINK: begin
          res_root_q   <= root_q;
          res_joined_q <= ra_ne_root;
        end
        default: begin
          res_root_q   <= '0;
          res_joined_q <= 1'b0;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_q.root   <= res_root_q;
      out_q.joined <= res_joined_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.sweep) begin
      cnt_d = (cnt_q == LastCell) ? '0 : cnt_q + CellW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  assign sts_o.op           = op_e'(op_q);
  assign sts_o.a_active     = ({1'b0, a_q} < ActiveLim);
  assign sts_o.b_active     = ({1'b0, b_q} < ActiveLim);
  assign sts_o.par_is_cur   = (rdata_q == cur_q);
  assign sts_o.start_is_cur = (start_q == cur_q);
  assign sts_o.par_is_root  = (rdata_q == root_q);
  assign sts_o.sweep_last   = (cnt_q == LastCell);
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

/* design/ufpc_ctrl.sv */
// Sequencer: walks, path compression, merge link and table sweeps.
`timescale 1ns / 1ps
module ufpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ufpc_pkg::dp_sts_t sts_i,
  output ufpc_pkg::dp_cmd_t cmd_o
);
  import ufpc_pkg::*;

  state_e state_q, state_d;
  logic   phase_b_q, phase_b_d;

  always_comb begin
    state_d   = state_q;
    phase_b_d = phase_b_q;
    unique case (state_q)
      S_INIT: begin
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        phase_b_d = 1'b0;
        unique case (sts_i.op)
          OP_FIND, OP_MERGE: state_d = sts_i.a_active ? S_WALK : S_RESP;
          OP_CLEAR:          state_d = S_CLEAR;
          default:           state_d = S_RESP;
        endcase
      end
      S_WALK: begin
        if (sts_i.par_is_cur) begin
          state_d = sts_i.start_is_cur ? S_FDONE : S_COMP;
        end
      end
      S_COMP: begin
        if (sts_i.par_is_root) state_d = S_FDONE;
      end
      S_FDONE: begin
        priority if (sts_i.op == OP_FIND) begin
          state_d = S_RESP;
        end else if (phase_b_q) begin
          state_d = S_LINK;
        end else begin
          state_d = sts_i.b_active ? S_STARTB : S_RESP;
        end
      end
      S_STARTB: begin
        phase_b_d = 1'b1;
        state_d   = S_WALK;
      end
      S_LINK:  state_d = S_RESP;
      S_CLEAR: begin
        if (sts_i.sweep_last) state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_INIT: cmd_o.sweep = 1'b1;
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_FIND, OP_MERGE: begin
            if (sts_i.a_active) begin
              cmd_o.walk_start = 1'b1;
            end else begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_A;
            end
          end
          OP_CLEAR: cmd_o.res_load = 1'b0;
          default: begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_ZERO;
          end
        endcase
      end
      S_WALK: begin
        if (sts_i.par_is_cur) begin
          cmd_o.root_take = 1'b1;
        end else begin
          cmd_o.walk_next = 1'b1;
        end
      end
      S_COMP: cmd_o.comp_step = 1'b1;
      S_FDONE: begin
        priority if (sts_i.op == OP_FIND) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_ROOT;
        end else if (!phase_b_q) begin
          cmd_o.save_ra = 1'b1;
          // b outside the grid: the answer is a's root
          cmd_o.res_load = !sts_i.b_active;
          cmd_o.res_sel  = RES_ROOT;
        end else begin
          cmd_o.res_load = 1'b0;
        end
      end
      S_STARTB: begin
        cmd_o.walk_start = 1'b1;
        cmd_o.sel_b      = 1'b1;
      end
      S_LINK: begin
        cmd_o.link     = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_LINK;
      end
      S_CLEAR: begin
        cmd_o.sweep    = 1'b1;
        cmd_o.res_load = sts_i.sweep_last;
        cmd_o.res_sel  = RES_ZERO;
      end
      S_RESP: cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      phase_b_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_b_q <= phase_b_d;
    end
  end

endmodule
